// ===== rtl/nott_pkg.sv =====
// shared types and constants of the note-off timer queue
package nott_pkg;

  localparam int WORD_W          = 32;
  localparam int ACTION_W        = 2;
  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int MAX_RESULTS     = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NOTE    = 2'd0,
    ACT_ADVANCE = 2'd1,
    ACT_FLUSH   = 2'd2
  } nott_action_t;

  typedef enum logic {
    KIND_NOTE_ON  = 1'b0,
    KIND_NOTE_OFF = 1'b1
  } nott_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_NWRITE,
    ST_FDONE,
    ST_FREAD,
    ST_FLAST
  } nott_state_t;

  typedef struct packed {
    logic [WORD_W-1:0] due;
    logic [WORD_W-1:0] pitch;
    logic [WORD_W-1:0] velocity;
  } nott_slot_t;

endpackage

// ===== rtl/nott_in_if.sv =====
// input channel: action and note fields
interface nott_in_if;
  logic                         valid;
  logic                         ready;
  logic [nott_pkg::ACTION_W-1:0] action;
  logic [nott_pkg::WORD_W-1:0]   pitch;
  logic [nott_pkg::WORD_W-1:0]   velocity;
  logic [nott_pkg::WORD_W-1:0]   note_length;
  logic [nott_pkg::WORD_W-1:0]   time_step;

  modport source (output valid, action, pitch, velocity, note_length, time_step, input ready);
  modport sink   (input valid, action, pitch, velocity, note_length, time_step, output ready);
endinterface

// ===== rtl/nott_out_if.sv =====
// result channel: note-on and note-off events
interface nott_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [nott_pkg::WORD_W-1:0] out_pitch;
  logic [nott_pkg::WORD_W-1:0] out_velocity;
  logic                        last;

  modport source (output valid, kind, out_pitch, out_velocity, last, input ready);
  modport sink   (input valid, kind, out_pitch, out_velocity, last, output ready);
endinterface

// ===== rtl/nott_store.sv =====
// slot memory with one write port and one registered read port
module nott_store #(
  parameter int DEPTH = nott_pkg::QUEUE_DEPTH_DEF,
  parameter int IW    = 5
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IW-1:0]       wr_addr,
  input  nott_pkg::nott_slot_t wr_data,
  input  logic [IW-1:0]       rd_addr,
  output nott_pkg::nott_slot_t rd_data
);
  import nott_pkg::*;

  nott_slot_t mem [DEPTH];
  nott_slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/note_off_timer_queue_top.sv =====
// note-off timer queue: top level with sequencer, slot valid bits and output register
// An advance beat moves the time and the block stays ready. A note beat scans the slots through
// the single read port of the slot memory, one slot per cycle, until it finds a held note of
// the same pitch that falls due earlier or has read the last slot. A flush beat runs one full
// minimum search per note-off, plus a final search that finds nothing more due (or stops
// after 32 note-offs), and then sends the last note-off beat if there is one. The block holds
// ready low while a note or flush is in work; a finished result waits in the output register
// without blocking the next input beat. At most 32 note-offs leave per flush; the rest stay
// stored for a later flush.
module note_off_timer_queue_top #(
  parameter int QUEUE_DEPTH = nott_pkg::QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  nott_in_if.sink    in_ch,
  nott_out_if.source out_ch
);
  import nott_pkg::*;

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(MAX_RESULTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(MAX_RESULTS - 1);

  nott_state_t  state_r, state_nxt;
  nott_action_t act_r, act_nxt;
  logic [WORD_W-1:0] pitch_r, pitch_nxt;
  logic [WORD_W-1:0] vel_r, vel_nxt;
  logic [WORD_W-1:0] due_r, due_nxt;
  logic [WORD_W-1:0] time_r, time_nxt;
  logic [QUEUE_DEPTH-1:0] valid_r, valid_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          iss_r, iss_nxt;
  logic          ev_r, ev_nxt;
  logic [IW-1:0] ev_idx_r, ev_idx_nxt;
  logic          best_has_r, best_has_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  logic [WORD_W-1:0] best_due_r, best_due_nxt;
  logic          free_has_r, free_has_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic          tgt_has_r, tgt_has_nxt;
  logic [IW-1:0] tgt_idx_r, tgt_idx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pend_has_r, pend_has_nxt;
  logic [WORD_W-1:0] pend_pitch_r, pend_pitch_nxt;
  logic [WORD_W-1:0] pend_vel_r, pend_vel_nxt;
  logic          ov_r, ov_nxt;
  logic          okind_r, okind_nxt;
  logic [WORD_W-1:0] opitch_r, opitch_nxt;
  logic [WORD_W-1:0] ovel_r, ovel_nxt;
  logic          olast_r, olast_nxt;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  nott_slot_t    wr_data;
  logic [IW-1:0] rd_addr;
  nott_slot_t    rd_data;
  logic          can_load;
  logic          ev_vbit;
  logic          cand;

  nott_store #(
    .DEPTH (QUEUE_DEPTH),
    .IW    (IW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = ov_r;
  assign out_ch.kind         = okind_r;
  assign out_ch.out_pitch    = opitch_r;
  assign out_ch.out_velocity = ovel_r;
  assign out_ch.last         = olast_r;

  assign can_load = !ov_r || out_ch.ready;
  assign rd_addr  = (state_r == ST_FDONE || state_r == ST_FREAD) ? best_idx_r : idx_r;
  assign ev_vbit  = valid_r[ev_idx_r];
  assign cand     = ev_vbit && (!best_has_r || rd_data.due < best_due_r);

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    pitch_nxt      = pitch_r;
    vel_nxt        = vel_r;
    due_nxt        = due_r;
    time_nxt       = time_r;
    valid_nxt      = valid_r;
    idx_nxt        = idx_r;
    iss_nxt        = iss_r;
    ev_nxt         = ev_r;
    ev_idx_nxt     = ev_idx_r;
    best_has_nxt   = best_has_r;
    best_idx_nxt   = best_idx_r;
    best_due_nxt   = best_due_r;
    free_has_nxt   = free_has_r;
    free_idx_nxt   = free_idx_r;
    tgt_has_nxt    = tgt_has_r;
    tgt_idx_nxt    = tgt_idx_r;
    cnt_nxt        = cnt_r;
    pend_has_nxt   = pend_has_r;
    pend_pitch_nxt = pend_pitch_r;
    pend_vel_nxt   = pend_vel_r;
    ov_nxt         = ov_r;
    okind_nxt      = okind_r;
    opitch_nxt     = opitch_r;
    ovel_nxt       = ovel_r;
    olast_nxt      = olast_r;
    wr_en          = 1'b0;
    wr_addr        = tgt_idx_r;
    wr_data        = '{due: due_r, pitch: pitch_r, velocity: vel_r};

    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          act_nxt   = nott_action_t'(in_ch.action);
          pitch_nxt = in_ch.pitch;
          vel_nxt   = in_ch.velocity;
          due_nxt   = time_r + in_ch.note_length;
          case (in_ch.action)
            ACT_NOTE: begin
              free_has_nxt = 1'b0;
              idx_nxt      = '0;
              iss_nxt      = 1'b1;
              ev_nxt       = 1'b0;
              state_nxt    = ST_SCAN;
            end
            ACT_ADVANCE: begin
              time_nxt = time_r + in_ch.time_step;
            end
            ACT_FLUSH: begin
              best_has_nxt = 1'b0;
              cnt_nxt      = '0;
              pend_has_nxt = 1'b0;
              idx_nxt      = '0;
              iss_nxt      = 1'b1;
              ev_nxt       = 1'b0;
              state_nxt    = ST_SCAN;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (iss_r) begin
          ev_nxt     = 1'b1;
          ev_idx_nxt = idx_r;
          if (idx_r == LAST_IDX) begin
            iss_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end else begin
          ev_nxt = 1'b0;
        end
        if (ev_r) begin
          if (act_r == ACT_NOTE) begin
            if (ev_vbit && rd_data.pitch == pitch_r && rd_data.due < due_r) begin
              tgt_has_nxt = 1'b1;
              tgt_idx_nxt = ev_idx_r;
              iss_nxt     = 1'b0;
              ev_nxt      = 1'b0;
              state_nxt   = ST_NWRITE;
            end else begin
              if (!ev_vbit && !free_has_r) begin
                free_has_nxt = 1'b1;
                free_idx_nxt = ev_idx_r;
              end
              if (ev_idx_r == LAST_IDX) begin
                tgt_has_nxt = free_has_r || !ev_vbit;
                tgt_idx_nxt = free_has_r ? free_idx_r : ev_idx_r;
                ev_nxt      = 1'b0;
                state_nxt   = ST_NWRITE;
              end
            end
          end else begin
            if (cand) begin
              best_has_nxt = 1'b1;
              best_idx_nxt = ev_idx_r;
              best_due_nxt = rd_data.due;
            end
            if (ev_idx_r == LAST_IDX) begin
              ev_nxt    = 1'b0;
              state_nxt = ST_FDONE;
            end
          end
        end
      end

      ST_NWRITE: begin
        if (!tgt_has_r) begin
          state_nxt = ST_IDLE;
        end else if (can_load) begin
          wr_en                  = 1'b1;
          valid_nxt[tgt_idx_r]   = 1'b1;
          ov_nxt                 = 1'b1;
          okind_nxt              = KIND_NOTE_ON;
          opitch_nxt             = pitch_r;
          ovel_nxt               = vel_r;
          olast_nxt              = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end

      ST_FDONE: begin
        if (best_has_r && best_due_r <= time_r) begin
          valid_nxt[best_idx_r] = 1'b0;
          state_nxt             = ST_FREAD;
        end else if (pend_has_r) begin
          state_nxt = ST_FLAST;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_FREAD: begin
        if (!pend_has_r || can_load) begin
          if (pend_has_r) begin
            ov_nxt     = 1'b1;
            okind_nxt  = KIND_NOTE_OFF;
            opitch_nxt = pend_pitch_r;
            ovel_nxt   = pend_vel_r;
            olast_nxt  = 1'b0;
          end
          pend_has_nxt   = 1'b1;
          pend_pitch_nxt = rd_data.pitch;
          pend_vel_nxt   = rd_data.velocity;
          cnt_nxt        = cnt_r + CW'(1);
          if (cnt_r == CNT_LAST) begin
            state_nxt = ST_FLAST;
          end else begin
            best_has_nxt = 1'b0;
            idx_nxt      = '0;
            iss_nxt      = 1'b1;
            ev_nxt       = 1'b0;
            state_nxt    = ST_SCAN;
          end
        end
      end

      ST_FLAST: begin
        if (can_load) begin
          ov_nxt       = 1'b1;
          okind_nxt    = KIND_NOTE_OFF;
          opitch_nxt   = pend_pitch_r;
          ovel_nxt     = pend_vel_r;
          olast_nxt    = 1'b1;
          pend_has_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      time_r     <= '0;
      valid_r    <= '0;
      iss_r      <= 1'b0;
      ev_r       <= 1'b0;
      pend_has_r <= 1'b0;
      ov_r       <= 1'b0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      time_r     <= time_nxt;
      valid_r    <= valid_nxt;
      iss_r      <= iss_nxt;
      ev_r       <= ev_nxt;
      pend_has_r <= pend_has_nxt;
      ov_r       <= ov_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    pitch_r      <= pitch_nxt;
    vel_r        <= vel_nxt;
    due_r        <= due_nxt;
    idx_r        <= idx_nxt;
    ev_idx_r     <= ev_idx_nxt;
    best_has_r   <= best_has_nxt;
    best_idx_r   <= best_idx_nxt;
    best_due_r   <= best_due_nxt;
    free_has_r   <= free_has_nxt;
    free_idx_r   <= free_idx_nxt;
    tgt_has_r    <= tgt_has_nxt;
    tgt_idx_r    <= tgt_idx_nxt;
    pend_pitch_r <= pend_pitch_nxt;
    pend_vel_r   <= pend_vel_nxt;
    okind_r      <= okind_nxt;
    opitch_r     <= opitch_nxt;
    ovel_r       <= ovel_nxt;
    olast_r      <= olast_nxt;
  end

endmodule

// ===== rtl/nott_checker.sv =====
// port-level assertions for the note-off timer queue and their binding
module nott_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [nott_pkg::ACTION_W-1:0] in_action,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_kind,
  input logic [nott_pkg::WORD_W-1:0] out_pitch,
  input logic [nott_pkg::WORD_W-1:0] out_velocity,
  input logic                        out_last
);
  import nott_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pitch) && $stable(out_velocity)
      && $stable(out_kind) && $stable(out_last))
    else $error("stalled result beat changed");

  a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_NOTE || in_action == ACT_FLUSH) |=> !in_ready)
    else $error("ready stayed high after a note or flush beat");

  a_note_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_NOTE_ON |-> out_last)
    else $error("note-on beat without last");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind note_off_timer_queue_top nott_checker u_nott_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_action    (in_ch.action),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_kind     (out_ch.kind),
  .out_pitch    (out_ch.out_pitch),
  .out_velocity (out_ch.out_velocity),
  .out_last     (out_ch.last)
);

// ===== tb/sv/note_off_timer_queue_top_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the note-off timer queue: directed table, then random beats
module note_off_timer_queue_top_test;
  import nott_pkg::*;

  localparam int DEPTH          = QUEUE_DEPTH_DEF;
  localparam int ITEMS_TARGET   = 430;
  localparam int MAX_GAP        = 12;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE         = 2 * DEPTH + 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int FILL_NOTES     = DEPTH + 2;
  localparam int SCRIPT_LEN     = 20;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [WORD_W-1:0]   ONES       = '1;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [WORD_W-1:0]   pitch;
    logic [WORD_W-1:0]   velocity;
    logic [WORD_W-1:0]   note_length;
    logic [WORD_W-1:0]   time_step;
    logic                has_exp;
    logic [1:0]          exp_n;
    nott_kind_t          exp_kind;
    logic [WORD_W-1:0]   exp_pitch;
    logic [WORD_W-1:0]   exp_vel;
  } stim_row_t;

  typedef struct packed {
    nott_kind_t        kind;
    logic [WORD_W-1:0] pitch;
    logic [WORD_W-1:0] velocity;
    logic              last;
  } note_evt_t;

  localparam stim_row_t SCRIPT [SCRIPT_LEN] = '{
    '{ACT_FLUSH,   '0, '0, '0, '0, 1'b1, 2'd0, KIND_NOTE_ON, '0, '0},
    '{ACT_ADVANCE, '0, '0, '0, '0, 1'b1, 2'd0, KIND_NOTE_ON, '0, '0},
    '{ACT_UNUSED,  ONES, ONES, ONES, ONES, 1'b1, 2'd0, KIND_NOTE_ON, '0, '0},
    '{ACT_NOTE,    '0, '0, '0, '0, 1'b1, 2'd1, KIND_NOTE_ON, '0, '0},
    '{ACT_NOTE,    ONES, ONES, ONES, '0, 1'b1, 2'd1, KIND_NOTE_ON, ONES, ONES},
    '{ACT_NOTE,    '0, 32'd5, 32'd10, '0, 1'b1, 2'd1, KIND_NOTE_ON, '0, 32'd5},
    '{ACT_NOTE,    '0, 32'd6, 32'd3, '0, 1'b1, 2'd1, KIND_NOTE_ON, '0, 32'd6},
    '{ACT_FLUSH,   '0, '0, '0, '0, 1'b1, 2'd0, KIND_NOTE_ON, '0, '0},
    '{ACT_ADVANCE, '0, '0, '0, 32'd3, 1'b1, 2'd0, KIND_NOTE_ON, '0, '0},
    '{ACT_FLUSH,   '0, '0, '0, '0, 1'b1, 2'd1, KIND_NOTE_OFF, '0, 32'd6},
    '{ACT_NOTE,    32'h1234_5678, 32'd1, '0, '0, 1'b0, 2'd0, KIND_NOTE_ON, '0, '0},
    '{ACT_NOTE,    32'hA5A5_A5A5, 32'd2, '0, '0, 1'b0, 2'd0, KIND_NOTE_ON, '0, '0},
    '{ACT_ADVANCE, '0, '0, '0, ONES, 1'b1, 2'd0, KIND_NOTE_ON, '0, '0},
    '{ACT_FLUSH,   '0, '0, '0, '0, 1'b0, 2'd0, KIND_NOTE_ON, '0, '0},
    '{ACT_ADVANCE, '0, '0, '0, 32'd8, 1'b1, 2'd0, KIND_NOTE_ON, '0, '0},
    '{ACT_FLUSH,   '0, '0, '0, '0, 1'b0, 2'd0, KIND_NOTE_ON, '0, '0},
    '{ACT_ADVANCE, '0, '0, '0, 32'hFFFF_FFF5, 1'b1, 2'd0, KIND_NOTE_ON, '0, '0},
    '{ACT_FLUSH,   '0, '0, '0, '0, 1'b0, 2'd0, KIND_NOTE_ON, '0, '0},
    '{ACT_NOTE,    ONES, 32'h8000_0001, 32'd1, '0, 1'b0, 2'd0, KIND_NOTE_ON, '0, '0},
    '{ACT_FLUSH,   '0, '0, '0, '0, 1'b0, 2'd0, KIND_NOTE_ON, '0, '0}
  };

  logic clk;
  logic rst_n;

  nott_in_if  in_ch ();
  nott_out_if out_ch ();

  note_off_timer_queue_top #(
    .QUEUE_DEPTH (DEPTH)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [WORD_W-1:0] now_tick;
  logic              held_live  [DEPTH];
  logic [WORD_W-1:0] held_due   [DEPTH];
  logic [WORD_W-1:0] held_pitch [DEPTH];
  logic [WORD_W-1:0] held_vel   [DEPTH];

  note_evt_t fresh_evts [$];
  note_evt_t note_events_q [$];

  int  fail_count;
  int  sent_beats;
  int  beats_by_action [4];
  int  drops;
  int  longest_flush;
  int  ons_seen;
  int  offs_seen;
  int  quiet_cycles;
  bit  src_calm;
  bit  sink_calm;
  bit  hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void log_failure(input string what);
    fail_count++;
    if (fail_count <= 10) begin
      $display("mismatch at %0t: %s", $time, what);
    end
  endfunction

  function automatic void predict_note_events(input logic [ACTION_W-1:0] act,
                                              input logic [WORD_W-1:0] p,
                                              input logic [WORD_W-1:0] v,
                                              input logic [WORD_W-1:0] len,
                                              input logic [WORD_W-1:0] step);
    int                hit;
    int                best;
    bit                searching;
    logic [WORD_W-1:0] due;
    fresh_evts.delete();
    case (act)
      ACT_NOTE: begin
        due = now_tick + len;
        hit = -1;
        for (int i = 0; i < DEPTH; i++) begin
          if (hit < 0 && held_live[i] && held_pitch[i] == p && held_due[i] < due) hit = i;
        end
        for (int i = 0; i < DEPTH; i++) begin
          if (hit < 0 && !held_live[i]) hit = i;
        end
        if (hit >= 0) begin
          held_live[hit]  = 1'b1;
          held_due[hit]   = due;
          held_pitch[hit] = p;
          held_vel[hit]   = v;
          fresh_evts.push_back(note_evt_t'{KIND_NOTE_ON, p, v, 1'b1});
        end else begin
          drops++;
        end
      end
      ACT_ADVANCE: now_tick = now_tick + step;
      ACT_FLUSH: begin
        searching = 1'b1;
        while (searching && fresh_evts.size() < MAX_RESULTS) begin
          best = -1;
          for (int i = 0; i < DEPTH; i++) begin
            if (held_live[i] && (best < 0 || held_due[i] < held_due[best])) best = i;
          end
          if (best < 0 || held_due[best] > now_tick) begin
            searching = 1'b0;
          end else begin
            held_live[best] = 1'b0;
            fresh_evts.push_back(note_evt_t'{KIND_NOTE_OFF, held_pitch[best],
                                             held_vel[best], 1'b0});
          end
        end
        if (fresh_evts.size() > 0) fresh_evts[fresh_evts.size()-1].last = 1'b1;
        if (fresh_evts.size() > longest_flush) longest_flush = fresh_evts.size();
      end
      default: ;
    endcase
  endfunction

  function automatic stim_row_t make_beat(input logic [ACTION_W-1:0] act,
                                          input logic [WORD_W-1:0] p,
                                          input logic [WORD_W-1:0] v,
                                          input logic [WORD_W-1:0] len,
                                          input logic [WORD_W-1:0] step);
    stim_row_t r;
    r             = '0;
    r.action      = act;
    r.pitch       = p;
    r.velocity    = v;
    r.note_length = len;
    r.time_step   = step;
    return r;
  endfunction

  task automatic send_beat(input stim_row_t r);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= r.action;
    in_ch.pitch       <= r.pitch;
    in_ch.velocity    <= r.velocity;
    in_ch.note_length <= r.note_length;
    in_ch.time_step   <= r.time_step;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_note_events(r.action, r.pitch, r.velocity, r.note_length, r.time_step);
    if (r.has_exp) begin
      if (r.exp_n != 0) begin
        note_events_q.push_back(note_evt_t'{r.exp_kind, r.exp_pitch, r.exp_vel, 1'b1});
      end
    end else begin
      foreach (fresh_evts[k]) note_events_q.push_back(fresh_evts[k]);
    end
    beats_by_action[r.action]++;
    if (r.action != ACT_UNUSED) sent_beats++;
  endtask

  task automatic drain_pause;
    in_ch.valid <= 1'b0;
    while (note_events_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // move time to the top of the range so that every held note is due, then flush
  task automatic sweep_store;
    send_beat(make_beat(ACT_ADVANCE, $urandom, $urandom, $urandom, ONES - now_tick));
    send_beat(make_beat(ACT_FLUSH, $urandom, $urandom, $urandom, $urandom));
  endtask

  initial begin : stimulus
    int                ph;
    int                mode;
    int                pick;
    logic [WORD_W-1:0] p;
    logic [WORD_W-1:0] pool [6];
    in_ch.valid       <= 1'b0;
    in_ch.action      <= ACT_NOTE;
    in_ch.pitch       <= '0;
    in_ch.velocity    <= '0;
    in_ch.note_length <= '0;
    in_ch.time_step   <= '0;
    rst_n             <= 1'b0;
    now_tick = '0;
    for (int i = 0; i < DEPTH; i++) held_live[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (SCRIPT[i]) send_beat(SCRIPT[i]);
    drain_pause();

    for (ph = 0; sent_beats < ITEMS_TARGET; ph++) begin
      mode      = (ph == 0) ? 0 : $urandom_range(0, 9);
      src_calm  = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      if (mode < 2) begin
        // fill the store past its depth while the result side is held off
        sweep_store();
        src_calm = 1'b1;
        hold_req = 1'b1;
        repeat (FILL_NOTES) begin
          send_beat(make_beat(ACT_NOTE, $urandom, $urandom, $urandom_range(0, 60), $urandom));
        end
        sweep_store();
        send_beat(make_beat(ACT_ADVANCE, $urandom, $urandom, $urandom, 200));
        send_beat(make_beat(ACT_FLUSH, $urandom, $urandom, $urandom, $urandom));
      end else if (mode < 8) begin
        for (int k = 0; k < 6; k++) pool[k] = (k == 0) ? '0 : (k == 1) ? ONES : $urandom;
        repeat (30) begin
          pick = $urandom_range(0, 19);
          p    = pool[$urandom_range(0, 5)];
          if (pick < 10) begin
            send_beat(make_beat(ACT_NOTE, p, $urandom,
                                ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 40),
                                $urandom));
          end else if (pick < 15) begin
            send_beat(make_beat(ACT_ADVANCE, $urandom, $urandom, $urandom,
                                ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 20)));
          end else if (pick < 19) begin
            send_beat(make_beat(ACT_FLUSH, p, $urandom, $urandom, $urandom));
          end else begin
            send_beat(make_beat(ACT_UNUSED, $urandom, $urandom, $urandom, $urandom));
          end
        end
        if ($urandom_range(0, 1) == 0) sweep_store();
      end else begin
        repeat (20) begin
          send_beat(make_beat(ACTION_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                              $urandom));
        end
        sweep_store();
      end
      drain_pause();
    end

    $display("covered %0d beats: %0d notes, %0d advances, %0d flushes, %0d ignored codes",
             sent_beats + beats_by_action[ACT_UNUSED], beats_by_action[ACT_NOTE],
             beats_by_action[ACT_ADVANCE], beats_by_action[ACT_FLUSH],
             beats_by_action[ACT_UNUSED]);
    $display("checked %0d note-ons and %0d note-offs, %0d notes dropped on a full store, %0s%0d",
             ons_seen, offs_seen, drops, "longest flush burst ", longest_flush);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : sink_side
    int gap;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  always @(posedge clk) begin : score_results
    note_evt_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (out_ch.kind == KIND_NOTE_OFF) offs_seen++;
      else ons_seen++;
      if (note_events_q.size() == 0) begin
        log_failure($sformatf("unexpected beat kind %0d pitch %h velocity %h last %0d",
                              out_ch.kind, out_ch.out_pitch, out_ch.out_velocity, out_ch.last));
      end else begin
        want = note_events_q.pop_front();
        if (out_ch.kind !== want.kind || out_ch.out_pitch !== want.pitch ||
            out_ch.out_velocity !== want.velocity || out_ch.last !== want.last) begin
          log_failure($sformatf("expected kind %0d pitch %h vel %h last %0d, got %0d %h %h %0d",
                                want.kind, want.pitch, want.velocity, want.last, out_ch.kind,
                                out_ch.out_pitch, out_ch.out_velocity, out_ch.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
               quiet_cycles, note_events_q.size());
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
